// ===== design/chlbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package chlbm_pkg;

   localparam int unsigned NUM_BUFFERS_DEF  = 4;
   localparam int unsigned BUFFER_BYTES_DEF = 4096;

   // longest line: 8 timestamp digits, 8 id digits, 16 data digits, newline
   localparam int unsigned LINE_MAX_CHARS = 8 + 8 + 16 + 1;
   localparam int unsigned MSG_BITS       = 32 + 32 + 64;
   localparam int unsigned CNT_W          = 6;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef enum logic [1:0] {
      OP_LOG       = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_FLUSH     = 2'd2,
      OP_NONE      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_FULL    = 2'd2
   } kind_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'h0, nib};
      end else begin
         ch = 8'h37 + {4'h0, nib};
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== design/chlbm_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface chlbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [31:0] timestamp;
   logic [31:0] sid;
   logic [3:0] dlc;
   logic [7:0] data_byte0;
   logic [7:0] data_byte1;
   logic [7:0] data_byte2;
   logic [7:0] data_byte3;
   logic [7:0] data_byte4;
   logic [7:0] data_byte5;
   logic [7:0] data_byte6;
   logic [7:0] data_byte7;

   modport source (
      output valid, output opcode, output timestamp, output sid, output dlc,
      output data_byte0, output data_byte1, output data_byte2, output data_byte3,
      output data_byte4, output data_byte5, output data_byte6, output data_byte7,
      input  ready
   );

   modport sink (
      input  valid, input opcode, input timestamp, input sid, input dlc,
      input  data_byte0, input data_byte1, input data_byte2, input data_byte3,
      input  data_byte4, input data_byte5, input data_byte6, input data_byte7,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/chlbm_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface chlbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  buffer_number;
   logic [11:0] offset;
   logic [7:0]  character;
   logic [12:0] release_length;
   logic        last;

   modport source (
      output valid, output kind, output buffer_number, output offset,
      output character, output release_length, output last,
      input  ready
   );

   modport sink (
      input  valid, input kind, input buffer_number, input offset,
      input  character, input release_length, input last,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/can_hex_log_buffer_manager_top.sv =====
// CAN message hex logger with a ring of NUM_BUFFERS log buffers.
// req_chan (valid/ready) carries one command beat: log a message, heartbeat
// (release ready buffers in ring order from the write pointer) or force flush
// (release every nonempty buffer). rsp_chan (valid/ready) returns the results
// of that beat in order, the final one flagged with last.
// A log beat emits one ASCII character per cycle, while the receiver does not
// stall, out of a 128-bit shift register that moves one hex digit per
// character: 17 to 33 characters, the first one registered once in ST_LOG. A
// log into a buffer still marked ready gives a single all-full result.
// A heartbeat or flush scans one buffer per cycle while the receiver does not
// stall; with nothing to release it gives no result and the block is ready
// again on the next cycle.
// req_chan.ready is high only between commands. rsp_chan has an output
// register; while the receiver stalls the engine holds its position, so no
// result is dropped or repeated.
// Reset (synchronous) clears the write pointer, all fill levels and ready
// flags at once; the block takes a command on the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module can_hex_log_buffer_manager_top #(
   parameter int unsigned NUM_BUFFERS  = chlbm_pkg::NUM_BUFFERS_DEF,
   parameter int unsigned BUFFER_BYTES = chlbm_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   chlbm_req_if.sink   req_chan,
   chlbm_rsp_if.source rsp_chan
);

   localparam int unsigned IDX_W  = $clog2(NUM_BUFFERS);
   localparam int unsigned FILL_W = $clog2(BUFFER_BYTES);
   localparam int unsigned CNT_W  = chlbm_pkg::CNT_W;
   localparam int unsigned MSG_W  = chlbm_pkg::MSG_BITS;
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_BUFFERS - 1);
   localparam logic [FILL_W-1:0] FULL_MARK =
      FILL_W'(BUFFER_BYTES - chlbm_pkg::LINE_MAX_CHARS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOG  = 4'b0010,
      ST_REL  = 4'b0100,
      ST_ERR  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      wp_ff, wp_in;
   logic [FILL_W-1:0]     fill_ff [NUM_BUFFERS];
   logic [FILL_W-1:0]     fill_in [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] ready_ff, ready_in;
   logic [NUM_BUFFERS-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [MSG_W-1:0]      msg_ff, msg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      nlast_ff, nlast_in;
   logic [FILL_W-1:0]     off_ff, off_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  bufnum_ff, bufnum_in;
   logic [11:0] offset_ff, offset_in;
   logic [7:0]  char_ff, char_in;
   logic [12:0] rlen_ff, rlen_in;
   logic        last_ff, last_in;

   logic [NUM_BUFFERS-1:0] nonempty;
   logic [NUM_BUFFERS-1:0] scan_hot;
   logic [NUM_BUFFERS-1:0] mask_clr;
   logic [IDX_W-1:0]       rd_idx;
   logic [FILL_W-1:0]      rd_fill;
   logic [FILL_W-1:0]      next_fill;
   logic [IDX_W-1:0]       scan_next;
   logic [3:0]             dlen;
   logic [7:0]             cur_char;
   logic                   out_free;
   logic                   accept;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         nonempty[i] = (fill_ff[i] != '0);
      end
   end

   // one read mux on the fill levels, shared by log and release
   assign rd_idx    = (state_ff == ST_REL) ? scan_ff : wp_ff;
   assign rd_fill   = fill_ff[rd_idx];
   assign next_fill = off_ff + FILL_W'(1);
   assign scan_hot  = NUM_BUFFERS'(1) << scan_ff;
   assign mask_clr  = mask_ff & ~scan_hot;
   assign scan_next = (scan_ff == LAST_IDX) ? '0 : scan_ff + IDX_W'(1);
   assign dlen      = (req_chan.dlc > 4'd8) ? 4'd8 : req_chan.dlc;
   assign cur_char  = (cnt_ff == nlast_ff) ? chlbm_pkg::CHAR_NEWLINE
                                           : chlbm_pkg::hex_char(msg_ff[MSG_W-1 -: 4]);

   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      ready_in = ready_ff;
      mask_in  = mask_ff;
      scan_in  = scan_ff;
      msg_in   = msg_ff;
      cnt_in   = cnt_ff;
      nlast_in = nlast_ff;
      off_in   = off_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      kind_in      = kind_ff;
      bufnum_in    = bufnum_ff;
      offset_in    = offset_ff;
      char_in      = char_ff;
      rlen_in      = rlen_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.opcode)
                  chlbm_pkg::OP_LOG: begin
                     if (ready_ff[wp_ff]) begin
                        state_in = ST_ERR;
                     end else begin
                        msg_in   = {req_chan.timestamp, req_chan.sid,
                                    req_chan.data_byte0, req_chan.data_byte1,
                                    req_chan.data_byte2, req_chan.data_byte3,
                                    req_chan.data_byte4, req_chan.data_byte5,
                                    req_chan.data_byte6, req_chan.data_byte7};
                        cnt_in   = '0;
                        nlast_in = CNT_W'(16) + {1'b0, dlen, 1'b0};
                        off_in   = rd_fill;
                        state_in = ST_LOG;
                     end
                  end
                  chlbm_pkg::OP_HEARTBEAT: begin
                     mask_in = ready_ff & nonempty;
                     scan_in = wp_ff;
                     if ((ready_ff & nonempty) != '0) begin
                        state_in = ST_REL;
                     end
                  end
                  chlbm_pkg::OP_FLUSH: begin
                     mask_in = nonempty;
                     scan_in = '0;
                     if (nonempty != '0) begin
                        state_in = ST_REL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = chlbm_pkg::KIND_CHAR;
               bufnum_in    = 2'(wp_ff);
               offset_in    = 12'(off_ff);
               char_in      = cur_char;
               rlen_in      = '0;
               last_in      = (cnt_ff == nlast_ff);
               msg_in       = msg_ff << 4;
               cnt_in       = cnt_ff + CNT_W'(1);
               off_in       = next_fill;
               if (cnt_ff == nlast_ff) begin
                  fill_in[wp_ff] = next_fill;
                  if (next_fill >= FULL_MARK) begin
                     ready_in[wp_ff] = 1'b1;
                     wp_in = (wp_ff == LAST_IDX) ? '0 : wp_ff + IDX_W'(1);
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REL: begin
            if (mask_ff[scan_ff]) begin
               if (out_free) begin
                  rsp_valid_in      = 1'b1;
                  kind_in           = chlbm_pkg::KIND_RELEASE;
                  bufnum_in         = 2'(scan_ff);
                  offset_in         = '0;
                  char_in           = '0;
                  rlen_in           = 13'(rd_fill);
                  last_in           = (mask_clr == '0);
                  fill_in[scan_ff]  = '0;
                  ready_in[scan_ff] = 1'b0;
                  mask_in           = mask_clr;
                  scan_in           = scan_next;
                  if (mask_clr == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               scan_in = scan_next;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = chlbm_pkg::KIND_FULL;
               bufnum_in    = 2'(wp_ff);
               offset_in    = '0;
               char_in      = '0;
               rlen_in      = '0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         ready_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      mask_ff   <= mask_in;
      scan_ff   <= scan_in;
      msg_ff    <= msg_in;
      cnt_ff    <= cnt_in;
      nlast_ff  <= nlast_in;
      off_ff    <= off_in;
      kind_ff   <= kind_in;
      bufnum_ff <= bufnum_in;
      offset_ff <= offset_in;
      char_ff   <= char_in;
      rlen_ff   <= rlen_in;
      last_ff   <= last_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = kind_ff;
   assign rsp_chan.buffer_number  = bufnum_ff;
   assign rsp_chan.offset         = offset_ff;
   assign rsp_chan.character      = char_ff;
   assign rsp_chan.release_length = rlen_ff;
   assign rsp_chan.last           = last_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG) |-> (cnt_ff <= nlast_ff))
      else $error("character count ran past end of line");

   a_rel_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL) |-> (mask_ff != '0))
      else $error("release scan with nothing left to release");

   a_line_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == chlbm_pkg::KIND_CHAR && last_ff)
         |-> (char_ff == chlbm_pkg::CHAR_NEWLINE))
      else $error("log line does not end in newline");

   a_open_room: assert property (@(posedge clock) disable iff (reset)
      !ready_ff[wp_ff] |-> (fill_ff[wp_ff] < FULL_MARK))
      else $error("open buffer lacks room for a full line");

   a_log_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG && cnt_ff == nlast_ff && out_free) |=> (state_ff == ST_IDLE))
      else $error("log engine did not finish after newline");

endmodule

`default_nettype wire
